>>> rtl/core/dtrs_pkg.sv
// shared types and constants for the transmit ring segment scheduler
package dtrs_pkg;

   localparam int DATA_W     = 8;
   localparam int INDEX_W    = 7;
   localparam int LEN_W      = 7;
   localparam int SEG_LEN_W  = 8;
   localparam int READ_SPAN  = 128;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_TX_DONE = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef struct packed {
      logic                  status;
      logic                  seg_start_valid;
      logic [INDEX_W-1:0]    seg_start;
      logic [SEG_LEN_W-1:0]  seg_length;
      logic [INDEX_W-1:0]    room;
   } result_type;

endpackage

>>> rtl/core/dma_tx_ring_segment_scheduler.sv
// top level: transmit ring buffer with dma segment scheduling
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_op .. req_read_index
//  rsp     | out       | rsp_valid, rsp_stall, rsp_status .. rsp_room
//
//  write and transmit-done results go straight into the result register; read
//  results pass first through the registered read port of the byte ram
//  one request in flight; the next is taken once no read is pending and the result
//  register is free or is being drained in the same cycle
//  reset clears pointers and handshake state; the byte ram needs no clearing
//  rsp_stall holds the result register and stalls req after one result
module dma_tx_ring_segment_scheduler #(
   parameter int DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [dtrs_pkg::DATA_W-1:0]       req_data_byte,
   input  logic                              req_first_of_frame,
   input  logic [dtrs_pkg::LEN_W-1:0]        req_frame_len,
   input  logic [dtrs_pkg::INDEX_W-1:0]      req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic                              rsp_seg_start_valid,
   output logic [dtrs_pkg::INDEX_W-1:0]      rsp_seg_start,
   output logic [dtrs_pkg::SEG_LEN_W-1:0]    rsp_seg_length,
   output logic [dtrs_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [dtrs_pkg::INDEX_W-1:0]      rsp_room
);
   import dtrs_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic              fire;
   logic              is_read;
   result_type        res;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] ram_rdata;
   logic [AW-1:0]     idx_map [READ_SPAN];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rd_pend_ff, rd_pend_in;
   result_type        res_ff;
   logic [DATA_W-1:0] read_data_ff;

   // read index wrapped onto the ring
   for (genvar g = 0; g < READ_SPAN; g++) begin : g_idx
      assign idx_map[g] = AW'(g % DEPTH);
   end

   assign req_stall = rd_pend_ff | (rsp_valid_ff & rsp_stall);
   assign fire      = req_valid & ~req_stall;
   assign is_read   = (req_op == OP_READ);

   dtrs_ring #(.DEPTH(DEPTH)) u_ring (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .op             (req_op),
      .data_byte      (req_data_byte),
      .first_of_frame (req_first_of_frame),
      .frame_len      (req_frame_len),
      .res            (res),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

   dtrs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (fire & is_read),
      .rd_addr (idx_map[req_read_index]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rd_pend_in   = fire & is_read;
      rsp_valid_in = rsp_valid_ff;
      if ((fire && !is_read) || rd_pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff       <= res;
         read_data_ff <= '0;
      end else if (rd_pend_ff) begin
         read_data_ff <= ram_rdata;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = res_ff.status;
   assign rsp_seg_start_valid = res_ff.seg_start_valid;
   assign rsp_seg_start       = res_ff.seg_start;
   assign rsp_seg_length      = res_ff.seg_length;
   assign rsp_read_data       = read_data_ff;
   assign rsp_room            = res_ff.room;

   a_pend_empty: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !rsp_valid_ff)
      else $error("read pending while result register full");

   a_read_lat: assert property (@(posedge clock) disable iff (reset)
      (fire && is_read) |=> ##1 rsp_valid_ff)
      else $error("read result not presented after ram latency");

   a_seg_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.seg_start_valid) |-> (res_ff.seg_length != '0))
      else $error("started segment has zero length");

   a_free_take: assert property (@(posedge clock) disable iff (reset)
      (!rd_pend_ff && !rsp_valid_ff) |-> !req_stall)
      else $error("request stalled while block empty");

endmodule

>>> rtl/core/dtrs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module dtrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dtrs_ring.sv
// ring pointers, frame admission and dma segment start logic
module dtrs_ring #(
   parameter int DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [1:0]                    op,
   input  logic [dtrs_pkg::DATA_W-1:0]   data_byte,
   input  logic                          first_of_frame,
   input  logic [dtrs_pkg::LEN_W-1:0]    frame_len,
   output dtrs_pkg::result_type          res,
   output logic                          wr_en,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output logic [dtrs_pkg::DATA_W-1:0]   wr_data
);
   import dtrs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(DEPTH + 1);
   localparam int LW = (AW > LEN_W) ? AW : LEN_W;
   localparam int XW = AW + 2;
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

   function automatic logic [AW-1:0] space_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
      if (w >= r) begin
         return LAST - (w - r);
      end
      return r - w - AW'(1);
   endfunction

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   logic [AW-1:0]    write_ptr_ff, write_ptr_in;
   logic [AW-1:0]    read_ptr_ff, read_ptr_in;
   logic [AW-1:0]    fill_ptr_ff, fill_ptr_in;
   logic [SW-1:0]    active_len_ff, active_len_in;
   logic             dma_busy_ff, dma_busy_in;
   logic [LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic             dropping_ff, dropping_in;

   logic [AW-1:0]    space_cur;
   logic             store;
   logic             ts_req;
   logic             ts_busy;
   logic [SW-1:0]    size;
   logic [XW-1:0]    tail_sum;

   always_comb begin
      write_ptr_in  = write_ptr_ff;
      read_ptr_in   = read_ptr_ff;
      fill_ptr_in   = fill_ptr_ff;
      active_len_in = active_len_ff;
      dma_busy_in   = dma_busy_ff;
      bytes_left_in = bytes_left_ff;
      dropping_in   = dropping_ff;
      wr_addr       = fill_ptr_ff;
      wr_data       = data_byte;
      store         = 1'b0;
      ts_req        = 1'b0;
      ts_busy       = dma_busy_ff;
      size          = '0;
      res           = '0;
      space_cur     = space_of(write_ptr_ff, read_ptr_ff);
      tail_sum      = XW'(read_ptr_ff) + XW'(active_len_ff);

      if (fire) begin
         case (op_type'(op))
            OP_WRITE: begin
               if (first_of_frame) begin
                  bytes_left_in = '0;
                  dropping_in   = 1'b0;
                  if (frame_len != '0) begin
                     bytes_left_in = frame_len - LEN_W'(1);
                     if (LW'(space_cur) < LW'(frame_len)) begin
                        res.status  = 1'b1;
                        dropping_in = (frame_len != LEN_W'(1));
                     end else begin
                        store   = 1'b1;
                        wr_addr = write_ptr_ff;
                     end
                  end
               end else if (bytes_left_ff != '0) begin
                  bytes_left_in = bytes_left_ff - LEN_W'(1);
                  if (dropping_ff) begin
                     res.status  = 1'b1;
                     dropping_in = (bytes_left_ff != LEN_W'(1));
                  end else begin
                     store = 1'b1;
                  end
               end
               if (store) begin
                  fill_ptr_in = next_ptr(wr_addr);
                  if (bytes_left_in == '0) begin
                     write_ptr_in = fill_ptr_in;
                     ts_req       = 1'b1;
                  end
               end
            end
            OP_TX_DONE: begin
               read_ptr_in   = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
               active_len_in = '0;
               dma_busy_in   = 1'b0;
               ts_busy       = 1'b0;
               ts_req        = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (ts_req && !ts_busy && (write_ptr_in != read_ptr_in)) begin
         size = (write_ptr_in > read_ptr_in) ? SW'(write_ptr_in - read_ptr_in)
                                             : DEPTH_S - SW'(read_ptr_in);
         dma_busy_in         = 1'b1;
         active_len_in       = size;
         res.seg_start_valid = 1'b1;
         res.seg_start       = INDEX_W'(read_ptr_in);
         res.seg_length      = SEG_LEN_W'(size);
      end

      wr_en    = store;
      res.room = INDEX_W'(space_of(write_ptr_in, read_ptr_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         read_ptr_ff   <= '0;
         fill_ptr_ff   <= '0;
         active_len_ff <= '0;
         dma_busy_ff   <= 1'b0;
         bytes_left_ff <= '0;
         dropping_ff   <= 1'b0;
      end else begin
         write_ptr_ff  <= write_ptr_in;
         read_ptr_ff   <= read_ptr_in;
         fill_ptr_ff   <= fill_ptr_in;
         active_len_ff <= active_len_in;
         dma_busy_ff   <= dma_busy_in;
         bytes_left_ff <= bytes_left_in;
         dropping_ff   <= dropping_in;
      end
   end

   // idle dma has no outstanding segment
   a_idle_no_len: assert property (@(posedge clock) disable iff (reset)
      !dma_busy_ff |-> (active_len_ff == '0))
      else $error("active length set while dma idle");

   a_busy_has_len: assert property (@(posedge clock) disable iff (reset)
      dma_busy_ff |-> (active_len_ff != '0))
      else $error("dma busy with empty segment");

   a_drop_open: assert property (@(posedge clock) disable iff (reset)
      (bytes_left_ff == '0) |-> !dropping_ff)
      else $error("dropping with no open frame");

endmodule

>>> tb/dma_tx_ring_segment_scheduler_test.sv
// self-checking testbench for the transmit ring segment scheduler
module dma_tx_ring_segment_scheduler_test;
   import dtrs_pkg::*;

   localparam int RING_DEPTH = 128;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                 status;
      logic                 seg_valid;
      logic [INDEX_W-1:0]   seg_start;
      logic [SEG_LEN_W-1:0] seg_length;
      logic [DATA_W-1:0]    read_data;
      logic [INDEX_W-1:0]   room;
   } ring_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = OP_WRITE;
   logic [DATA_W-1:0]    req_data_byte = '0;
   logic                 req_first_of_frame = 1'b0;
   logic [LEN_W-1:0]     req_frame_len = '0;
   logic [INDEX_W-1:0]   req_read_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_status;
   logic                 rsp_seg_start_valid;
   logic [INDEX_W-1:0]   rsp_seg_start;
   logic [SEG_LEN_W-1:0] rsp_seg_length;
   logic [DATA_W-1:0]    rsp_read_data;
   logic [INDEX_W-1:0]   rsp_room;

   // mirrored ring state
   logic [DATA_W-1:0]    ring_bytes [RING_DEPTH];
   logic [RING_DEPTH-1:0] entry_written = '0;
   logic [INDEX_W-1:0]   ring_head = '0;
   logic [INDEX_W-1:0]   ring_tail = '0;
   logic [INDEX_W-1:0]   fill_ptr = '0;
   logic [SEG_LEN_W-1:0] active_len = '0;
   logic                 dma_busy = 1'b0;
   logic [LEN_W-1:0]     bytes_left = '0;
   logic                 dropping = 1'b0;

   ring_result_type ring_results_due[$];
   int unsigned  error_count = 0;
   int unsigned  useful_items = 0;
   bit           feed_idling = 1'b1;
   bit           sink_idling = 1'b1;
   int unsigned  hold_request = 0;
   int unsigned  stall_left = 0;

   dma_tx_ring_segment_scheduler #(.DEPTH(RING_DEPTH)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_data_byte(req_data_byte),
      .req_first_of_frame(req_first_of_frame),
      .req_frame_len(req_frame_len),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_seg_start_valid(rsp_seg_start_valid),
      .rsp_seg_start(rsp_seg_start),
      .rsp_seg_length(rsp_seg_length),
      .rsp_read_data(rsp_read_data),
      .rsp_room(rsp_room)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [INDEX_W-1:0] ring_free();
      return INDEX_W'(ring_tail - ring_head - 7'd1);
   endfunction

   function automatic void try_segment(inout ring_result_type r);
      if (dma_busy || ring_head == ring_tail) return;
      active_len = (ring_head > ring_tail) ? SEG_LEN_W'(ring_head - ring_tail)
                                           : SEG_LEN_W'(RING_DEPTH - ring_tail);
      dma_busy = 1'b1;
      r.seg_valid = 1'b1;
      r.seg_start = ring_tail;
      r.seg_length = active_len;
   endfunction

   function automatic void store_frame_byte(input logic [DATA_W-1:0] data,
                                            inout ring_result_type r);
      ring_bytes[fill_ptr] = data;
      entry_written[fill_ptr] = 1'b1;
      fill_ptr = fill_ptr + 7'd1;
      bytes_left = bytes_left - 7'd1;
      if (bytes_left == 0) begin
         ring_head = fill_ptr;
         try_segment(r);
      end
   endfunction

   // applies one accepted request, queues its result, returns 1 if it was ignored
   function automatic bit advance_ring(input logic [1:0] op, input logic [DATA_W-1:0] data,
                                       input logic first, input logic [LEN_W-1:0] len,
                                       input logic [INDEX_W-1:0] idx);
      ring_result_type r;
      bit ignored;
      r = '0;
      ignored = 1'b0;
      case (op)
         OP_WRITE: begin
            if (first) begin
               bytes_left = '0;
               dropping = 1'b0;
               if (len == 0) begin
                  ignored = 1'b1;
               end else begin
                  bytes_left = len;
                  if (ring_free() < len) begin
                     dropping = 1'b1;
                     r.status = 1'b1;
                     bytes_left = bytes_left - 7'd1;
                     if (bytes_left == 0) dropping = 1'b0;
                  end else begin
                     fill_ptr = ring_head;
                     store_frame_byte(data, r);
                  end
               end
            end else if (bytes_left == 0) begin
               ignored = 1'b1;
            end else if (dropping) begin
               r.status = 1'b1;
               bytes_left = bytes_left - 7'd1;
               if (bytes_left == 0) dropping = 1'b0;
            end else begin
               store_frame_byte(data, r);
            end
         end
         OP_TX_DONE: begin
            ring_tail = INDEX_W'(ring_tail + active_len);
            active_len = '0;
            dma_busy = 1'b0;
            try_segment(r);
         end
         OP_READ: r.read_data = ring_bytes[idx];
         default: ignored = 1'b1;
      endcase
      r.room = ring_free();
      ring_results_due.push_back(r);
      return ignored;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      ring_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_results_due.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_room), 0);
         end else begin
            want = ring_results_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_seg_start_valid !== want.seg_valid)
               report_mismatch("seg_start_valid", 32'(rsp_seg_start_valid),
                               32'(want.seg_valid));
            if (rsp_seg_start !== want.seg_start)
               report_mismatch("seg_start", 32'(rsp_seg_start), 32'(want.seg_start));
            if (rsp_seg_length !== want.seg_length)
               report_mismatch("seg_length", 32'(rsp_seg_length), 32'(want.seg_length));
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", 32'(rsp_read_data), 32'(want.read_data));
            if (rsp_room !== want.room)
               report_mismatch("room", 32'(rsp_room), 32'(want.room));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request != 0) begin
         rsp_stall <= 1'b1;
         stall_left = hold_request - 1;
         hold_request = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic issue_request(input logic [1:0] op, input logic [DATA_W-1:0] data,
                                input logic first, input logic [LEN_W-1:0] len,
                                input logic [INDEX_W-1:0] idx);
      int unsigned gap;
      gap = (feed_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= data;
      req_first_of_frame <= first;
      req_frame_len <= len;
      req_read_index <= idx;
      do @(posedge clock); while (req_stall);
      if (!advance_ring(op, data, first, len, idx)) useful_items++;
   endtask

   task automatic drain_ring();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ring_results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [INDEX_W-1:0] pick_read_index();
      logic [INDEX_W-1:0] idx;
      if (dma_busy && $urandom_range(0, 3) != 0)
         return INDEX_W'(ring_tail + $urandom_range(0, active_len - 1));
      idx = INDEX_W'($urandom);
      while (!entry_written[idx]) idx = idx + 7'd1;
      return idx;
   endfunction

   task automatic send_tx_done_or_read();
      if (entry_written != '0 && $urandom_range(0, 1) == 0)
         issue_request(OP_READ, 8'($urandom), 1'($urandom), 7'($urandom),
                       pick_read_index());
      else
         issue_request(OP_TX_DONE, 8'($urandom), 1'($urandom), 7'($urandom),
                       7'($urandom));
   endtask

   task automatic send_frame();
      int unsigned len;
      int unsigned cut;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) : $urandom_range(1, 16);
      cut = (len > 1 && $urandom_range(0, 15) == 0) ? $urandom_range(1, len - 1) : len;
      issue_request(OP_WRITE, 8'($urandom), 1'b1, 7'(len), 7'($urandom));
      for (int i = 1; i < cut; i++) begin
         if ($urandom_range(0, 9) == 0) send_tx_done_or_read();
         issue_request(OP_WRITE, 8'($urandom), 1'b0, 7'($urandom), 7'($urandom));
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: issue_request(OP_WRITE, 8'($urandom), 1'b0, 7'($urandom), 7'($urandom));
         1: issue_request(OP_WRITE, 8'($urandom), 1'b1, '0, 7'($urandom));
         default: issue_request(OP_UNUSED, 8'($urandom), 1'($urandom), 7'($urandom),
                                7'($urandom));
      endcase
   endtask

   task automatic run_random_traffic(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      goal = useful_items + count;
      while (useful_items < goal) begin
         pick = $urandom_range(0, 99);
         if (dma_busy && (pick < 20 || (ring_free() < 40 && pick < 50)))
            issue_request(OP_TX_DONE, 8'($urandom), 1'($urandom), 7'($urandom),
                          7'($urandom));
         else if (pick < 70)
            send_frame();
         else if (pick < 92)
            send_tx_done_or_read();
         else
            send_noise();
      end
   endtask

   task automatic test_single_byte_frame();
      issue_request(OP_WRITE, 8'hFF, 1'b1, 7'd1, 7'd0);
      issue_request(OP_READ, 8'h00, 1'b0, 7'd0, 7'd0);
      issue_request(OP_TX_DONE, 8'h00, 1'b0, 7'd0, 7'h7F);
   endtask

   task automatic test_multi_byte_frame();
      issue_request(OP_WRITE, 8'h00, 1'b1, 7'd3, 7'd0);
      issue_request(OP_WRITE, 8'hA5, 1'b0, 7'd0, 7'd0);
      issue_request(OP_WRITE, 8'h5A, 1'b0, 7'd0, 7'd0);
      issue_request(OP_READ, 8'h00, 1'b0, 7'd0, 7'd1);
      issue_request(OP_READ, 8'h00, 1'b0, 7'd0, 7'd2);
      issue_request(OP_READ, 8'h00, 1'b1, 7'h7F, 7'd3);
      issue_request(OP_TX_DONE, 8'h00, 1'b0, 7'd0, 7'd0);
   endtask

   task automatic test_special_cases();
      // transmit done while idle, stray byte, zero length, unused op
      issue_request(OP_TX_DONE, 8'hFF, 1'b1, 7'h7F, 7'h7F);
      issue_request(OP_WRITE, 8'h12, 1'b0, 7'd5, 7'd0);
      issue_request(OP_WRITE, 8'h34, 1'b1, 7'd0, 7'd0);
      issue_request(OP_UNUSED, 8'hFF, 1'b1, 7'h7F, 7'h7F);
      // open frame abandoned by a new first byte
      issue_request(OP_WRITE, 8'h11, 1'b1, 7'd4, 7'd0);
      issue_request(OP_WRITE, 8'h22, 1'b0, 7'd0, 7'd0);
      issue_request(OP_WRITE, 8'h33, 1'b1, 7'd2, 7'd0);
      issue_request(OP_WRITE, 8'h44, 1'b0, 7'd0, 7'd0);
   endtask

   task automatic test_rejected_frame();
      issue_request(OP_WRITE, 8'h80, 1'b1, 7'h7F, 7'd0);
      issue_request(OP_WRITE, 8'h81, 1'b0, 7'd0, 7'd0);
      issue_request(OP_WRITE, 8'hC3, 1'b1, 7'd1, 7'd0);
      issue_request(OP_TX_DONE, 8'h00, 1'b0, 7'd0, 7'd0);
      issue_request(OP_TX_DONE, 8'h00, 1'b0, 7'd0, 7'd0);
   endtask

   task automatic test_random_traffic();
      run_random_traffic(1000);
   endtask

   task automatic test_receiver_hold();
      hold_request = 80;
      run_random_traffic(40);
   endtask

   task automatic test_sender_pause();
      drain_ring();
      run_random_traffic(250);
   endtask

   task automatic test_back_to_back();
      feed_idling = 1'b0;
      sink_idling = 1'b0;
      run_random_traffic(250);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_single_byte_frame();
      test_multi_byte_frame();
      test_special_cases();
      test_rejected_frame();
      test_random_traffic();
      test_receiver_hold();
      test_sender_pause();
      test_back_to_back();
      drain_ring();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/dtrs_pkg.sv
rtl/core/dtrs_ram.sv
rtl/core/dtrs_ring.sv
rtl/core/dma_tx_ring_segment_scheduler.sv
tb/dma_tx_ring_segment_scheduler_test.sv
